@@ hdl/class_stats_interval_classifier_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the interval classifier
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CLASS_STATS_INTERVAL_CLASSIFIER_TOP_DEFINES_SVH
`define CLASS_STATS_INTERVAL_CLASSIFIER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define CSIC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("csic check failed");
// A condition that must never be seen outside reset.
`define CSIC_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("csic forbidden condition seen");
`else
`define CSIC_ASSERT(lbl, clk, rst_n, prop)
`define CSIC_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ hdl/csic_pkg.sv @@
// ----------------------------------------------------------------------------
// csic_pkg
// Shared constants, register indexes and status types of the classifier.
// ----------------------------------------------------------------------------
package csic_pkg;

  // Row layout: eight feature columns, the label column follows them.
  localparam int FEATURES     = 8;
  localparam int FEAT_IDX_W   = $clog2(FEATURES);
  localparam int COLUMNS      = 9;
  localparam int LABEL_COLUMN = 9 - 1;
  localparam int COL_W        = 4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PRICE_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SELECTED_COLUMN = 1'd1;

  // Queue between front and back; the depth is a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Digit width of the shared squarer.
  localparam int DIGIT_W = 16;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } csic_q_stat_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } csic_bk_stat_t;

endpackage

@@ hdl/csic_front.sv @@
// ----------------------------------------------------------------------------
// csic_front
// Holds the configuration, labels each accepted row and selects its value.
// ----------------------------------------------------------------------------
module csic_front import csic_pkg::*; #(
  parameter int VALUE_BITS = 24,
  localparam int RowW = VALUE_BITS + 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [VALUE_BITS-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] in_feature [FEATURES],
  input  logic [VALUE_BITS-1:0] in_price_value,
  input  logic                  in_last_row,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [RowW-1:0]       q_wdata
);

  logic signed [VALUE_BITS-1:0] thr_r;
  logic [COL_W-1:0]             sel_r;
  logic                         f_vld_r;
  logic [RowW-1:0]              f_word_r;

  logic                         accept;
  logic                         label;
  logic [COL_W-1:0]             col_sat;
  logic [VALUE_BITS-1:0]        x_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      sel_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRICE_THRESHOLD: thr_r <= cfg_data;
        REG_SELECTED_COLUMN: sel_r <= cfg_data[COL_W-1:0];
        default: ;
      endcase
    end
  end

  // Columns above the label column act as the label column.
  always_comb begin
    label   = $signed(in_price_value) >= thr_r;
    col_sat = (sel_r > COL_W'(LABEL_COLUMN)) ? COL_W'(LABEL_COLUMN) : sel_r;
    if (col_sat == COL_W'(LABEL_COLUMN)) begin
      x_sel = {{(VALUE_BITS-1){1'b0}}, label};
    end else begin
      x_sel = in_feature[col_sat[FEAT_IDX_W-1:0]];
    end
  end

  assign in_stall = f_vld_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = f_vld_r && !q_full;
  assign q_wdata  = f_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= accept || in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_word_r <= {in_last_row, label, x_sel};
    end
  end

endmodule

@@ hdl/csic_queue.sv @@
// ----------------------------------------------------------------------------
// csic_queue
// Short first-in first-out queue of classified rows.
// ----------------------------------------------------------------------------
module csic_queue import csic_pkg::*; #(
  parameter int W = 26
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output csic_q_stat_t stat
);

  logic [W-1:0]      slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = slot_r[rd_ptr_r];
  assign stat.count = cnt_r;
  assign stat.full  = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign stat.empty = cnt_r == '0;

endmodule

@@ hdl/csic_sqr.sv @@
// ----------------------------------------------------------------------------
// csic_sqr
// Digit-serial squarer: one operand-by-digit product per cycle, top digit first.
// ----------------------------------------------------------------------------
module csic_sqr import csic_pkg::*; #(
  parameter int W = 31
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   operand,
  output logic           done,
  output logic [2*W-1:0] result
);

  localparam int ND   = (W + DIGIT_W - 1) / DIGIT_W;
  localparam int PADW = ND * DIGIT_W;
  localparam int PW   = 2 * W;
  localparam int CW   = $clog2(ND + 1);

  logic [W-1:0]         a_r;
  logic [PADW-1:0]      dig_r;
  logic [PW-1:0]        acc_r;
  logic [CW-1:0]        cnt_r;
  logic                 done_r;
  logic [W+DIGIT_W-1:0] part;
  logic [PW-1:0]        acc_nxt;

  // Partial sums stay below the final square, so the shifted sum fits.
  assign part    = {{DIGIT_W{1'b0}}, a_r} * {{W{1'b0}}, dig_r[PADW-1 -: DIGIT_W]};
  assign acc_nxt = (acc_r << DIGIT_W) + PW'(part);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CW'(ND);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - CW'(1);
      done_r <= cnt_r == CW'(1);
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= operand;
      dig_r <= PADW'(operand);
      acc_r <= '0;
    end else if (cnt_r != '0) begin
      acc_r <= acc_nxt;
      dig_r <= dig_r << DIGIT_W;
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

@@ hdl/csic_back.sv @@
// ----------------------------------------------------------------------------
// csic_back
// Stores rows, gathers expensive-class statistics and emits the predictions.
// ----------------------------------------------------------------------------
module csic_back import csic_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int VALUE_BITS = 24,
  localparam int CntW = $clog2(MAX_ROWS + 1),
  localparam int RowW = VALUE_BITS + 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [RowW-1:0] q_data,
  input  csic_q_stat_t    q_stat,
  output csic_bk_stat_t   bk_stat,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_prediction,
  output logic            out_true_label,
  output logic [CntW-1:0] out_correct_so_far,
  output logic            out_too_few_expensive,
  output logic            out_last_result
);

  localparam int VB = VALUE_BITS;
  localparam int AW = $clog2(MAX_ROWS);
  localparam int XW = 2 * VB;
  localparam int QW = 2 * VB + CntW;
  localparam int MW = VB + CntW;
  localparam int DW = MW + 1;
  localparam int PW = 2 * MW;
  localparam int LW = PW + CntW;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_FIN_START,
    ST_FIN_WAIT,
    ST_FIN_RHS,
    ST_EMIT_RD,
    ST_EMIT_NX,
    ST_EMIT_D,
    ST_EMIT_SQ,
    ST_EMIT_OUT
  } state_t;

  state_t               state_r;
  logic                 a_vld_r;
  logic signed [VB-1:0] a_x_r;
  logic                 a_lab_r;
  logic                 b_vld_r;
  logic                 b_acc_r;
  logic [XW-1:0]        b_sq_r;
  logic [CntW-1:0]      row_cnt_r;
  logic [CntW-1:0]      n_r;
  logic [MW-1:0]        s_r;
  logic [QW-1:0]        q_r;
  logic [CntW-1:0]      corr_r;
  logic [CntW-1:0]      emit_idx_r;
  logic [PW-1:0]        nq_r;
  logic [PW-1:0]        var_r;
  logic [LW-1:0]        rhs_r;
  logic                 few_r;
  logic signed [DW-1:0] nx_r;
  logic                 lab_r;
  logic [LW-1:0]        lhs_r;
  logic [VB:0]          rd_r;
  logic [VB:0]          row_mem [MAX_ROWS];
  logic                 out_vld_r;
  logic                 out_pred_r;
  logic                 out_lab_r;
  logic [CntW-1:0]      out_corr_r;
  logic                 out_few_r;
  logic                 out_last_r;

  logic                 pop;
  logic                 room;
  logic                 a_store;
  logic                 a_acc;
  logic signed [XW-1:0] a_x_xw;
  logic signed [XW-1:0] x_sq;
  logic [PW-1:0]        nq_nxt;
  logic [LW-1:0]        rhs_nxt;
  logic signed [DW-1:0] n_dw;
  logic signed [DW-1:0] x_dw;
  logic signed [DW-1:0] nx_nxt;
  logic [DW-1:0]        s_dw;
  logic [DW-1:0]        d_pos;
  logic [DW-1:0]        d_neg;
  logic [MW-1:0]        dmag;
  logic [MW-1:0]        s_neg;
  logic [MW-1:0]        smag;
  logic [CntW-1:0]      nm1;
  logic [LW-1:0]        lhs_nxt;
  logic                 pred;
  logic [CntW-1:0]      corr_nxt;
  logic                 last_nxt;
  logic                 out_free;
  logic                 sq_start;
  logic [MW-1:0]        sq_op;
  logic                 sq_done;
  logic [PW-1:0]        sq_res;

  assign pop     = (state_r == ST_LOAD) && !q_stat.empty;
  assign room    = row_cnt_r < CntW'(MAX_ROWS);
  assign a_store = a_vld_r && room;
  assign a_acc   = a_store && a_lab_r;

  always_comb begin
    a_x_xw  = {{VB{a_x_r[VB-1]}}, a_x_r};
    x_sq    = a_x_xw * a_x_xw;
    nq_nxt  = {{(PW-CntW){1'b0}}, n_r} * {{(PW-QW){1'b0}}, q_r};
    rhs_nxt = {{CntW{1'b0}}, var_r} * {{PW{1'b0}}, n_r};
    n_dw    = {{(DW-CntW){1'b0}}, n_r};
    x_dw    = {{(DW-VB){rd_r[VB-1]}}, rd_r[VB-1:0]};
    nx_nxt  = n_dw * x_dw;
    s_dw    = {s_r[MW-1], s_r};
    d_pos   = nx_r - s_dw;
    d_neg   = s_dw - nx_r;
    dmag    = d_pos[DW-1] ? d_neg[MW-1:0] : d_pos[MW-1:0];
    s_neg   = -s_r;
    smag    = s_r[MW-1] ? s_neg : s_r;
    nm1     = n_r - CntW'(1);
    lhs_nxt = {{CntW{1'b0}}, sq_res} * {{PW{1'b0}}, nm1};
  end

  // With fewer than two expensive rows the interval is undefined: predict 1.
  assign pred     = few_r || (lhs_r <= rhs_r);
  assign corr_nxt = corr_r + CntW'(pred == lab_r);
  assign last_nxt = (emit_idx_r + CntW'(1)) == row_cnt_r;
  assign out_free = !out_vld_r || !out_stall;

  assign sq_start = (state_r == ST_FIN_START) || (state_r == ST_EMIT_D);
  assign sq_op    = (state_r == ST_FIN_START) ? smag : dmag;

  csic_sqr #(
    .W(MW)
  ) u_sqr (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .operand(sq_op),
    .done   (sq_done),
    .result (sq_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      a_vld_r    <= 1'b0;
      b_vld_r    <= 1'b0;
      row_cnt_r  <= '0;
      n_r        <= '0;
      s_r        <= '0;
      q_r        <= '0;
      corr_r     <= '0;
      emit_idx_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      a_vld_r <= pop;
      b_vld_r <= a_vld_r;
      if (a_store) begin
        row_cnt_r <= row_cnt_r + CntW'(1);
        if (a_lab_r) begin
          n_r <= n_r + CntW'(1);
          s_r <= s_r + {{(MW-VB){a_x_r[VB-1]}}, a_x_r};
        end
      end
      if (b_vld_r && b_acc_r) begin
        q_r <= q_r + {{(QW-XW){1'b0}}, b_sq_r};
      end
      // A taken result empties the output register unless the next one
      // moves in at the same edge.
      if (out_vld_r && !out_stall && (state_r != ST_EMIT_OUT)) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        ST_LOAD: begin
          if (pop && q_data[VB+1]) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!a_vld_r && !b_vld_r) begin
            state_r <= ST_FIN_START;
          end
        end
        ST_FIN_START: state_r <= ST_FIN_WAIT;
        ST_FIN_WAIT: begin
          if (sq_done) begin
            state_r <= ST_FIN_RHS;
          end
        end
        ST_FIN_RHS: begin
          emit_idx_r <= '0;
          state_r    <= ST_EMIT_RD;
        end
        ST_EMIT_RD: state_r <= ST_EMIT_NX;
        ST_EMIT_NX: state_r <= ST_EMIT_D;
        ST_EMIT_D:  state_r <= ST_EMIT_SQ;
        ST_EMIT_SQ: begin
          if (sq_done) begin
            state_r <= ST_EMIT_OUT;
          end
        end
        ST_EMIT_OUT: begin
          if (out_free) begin
            out_vld_r  <= 1'b1;
            out_pred_r <= pred;
            out_lab_r  <= lab_r;
            out_corr_r <= corr_nxt;
            out_few_r  <= few_r;
            out_last_r <= last_nxt;
            corr_r     <= last_nxt ? '0 : corr_nxt;
            if (last_nxt) begin
              row_cnt_r <= '0;
              n_r       <= '0;
              s_r       <= '0;
              q_r       <= '0;
              state_r   <= ST_LOAD;
            end else begin
              emit_idx_r <= emit_idx_r + CntW'(1);
              state_r    <= ST_EMIT_RD;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_x_r   <= q_data[VB-1:0];
      a_lab_r <= q_data[VB];
    end
    b_acc_r <= a_acc;
    b_sq_r  <= x_sq;
    if (state_r == ST_FIN_START) begin
      nq_r  <= nq_nxt;
      few_r <= n_r < CntW'(2);
    end
    if ((state_r == ST_FIN_WAIT) && sq_done) begin
      var_r <= nq_r - sq_res;
    end
    if (state_r == ST_FIN_RHS) begin
      rhs_r <= rhs_nxt;
    end
    if (state_r == ST_EMIT_NX) begin
      nx_r  <= nx_nxt;
      lab_r <= rd_r[VB];
    end
    if ((state_r == ST_EMIT_SQ) && sq_done) begin
      lhs_r <= lhs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_store) begin
      row_mem[row_cnt_r[AW-1:0]] <= {a_lab_r, a_x_r};
    end
    rd_r <= row_mem[emit_idx_r[AW-1:0]];
  end

  assign bk_stat.busy          = state_r != ST_LOAD;
  assign bk_stat.pop           = pop;
  assign out_valid             = out_vld_r;
  assign out_prediction        = out_pred_r;
  assign out_true_label        = out_lab_r;
  assign out_correct_so_far    = out_corr_r;
  assign out_too_few_expensive = out_few_r;
  assign out_last_result       = out_last_r;

endmodule

@@ hdl/class_stats_interval_classifier_top.sv @@
// ----------------------------------------------------------------------------
// class_stats_interval_classifier_top: rows load at one per cycle unless stalled; each
// result passes the back end's read, n*x, difference, square and output steps, paced by
// the shared digit-serial squarer over ND = ceil((VALUE_BITS + clog2(MAX_ROWS+1)) / 16)
// digits. Synchronous active-low reset clears control and counters only.
// ----------------------------------------------------------------------------
`include "class_stats_interval_classifier_top_defines.svh"

// The front end registers each accepted word, labels it against the price
// threshold and picks the value of the selected column. Classified rows wait
// in a short queue that takes input while the back end is busy, until full.
//
// The back end pops rows, writes them to its row memory and accumulates the
// count, sum and sum of squares of the expensive rows. Once the row marked
// last has drained through, it squares the sum, forms n*Q - S^2 and scales it
// by n. It then walks the stored rows in load order, forming (n*x - S)^2 and
// scaling it by n - 1, and compares both sides exactly. Each result sits in an
// output register, so the next row's work goes on while a result is stalled.
//
// Rows beyond MAX_ROWS are dropped; a dropped last row still starts the
// emit walk. The row memory is not cleared: only entries written in the
// current run are ever read.
module class_stats_interval_classifier_top import csic_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int VALUE_BITS = 24,
  localparam int CntW = $clog2(MAX_ROWS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [VALUE_BITS-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] in_feature_0,
  input  logic [VALUE_BITS-1:0] in_feature_1,
  input  logic [VALUE_BITS-1:0] in_feature_2,
  input  logic [VALUE_BITS-1:0] in_feature_3,
  input  logic [VALUE_BITS-1:0] in_feature_4,
  input  logic [VALUE_BITS-1:0] in_feature_5,
  input  logic [VALUE_BITS-1:0] in_feature_6,
  input  logic [VALUE_BITS-1:0] in_feature_7,
  input  logic [VALUE_BITS-1:0] in_price_value,
  input  logic                  in_last_row,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_prediction,
  output logic                  out_true_label,
  output logic [CntW-1:0]       out_correct_so_far,
  output logic                  out_too_few_expensive,
  output logic                  out_last_result
);

  // A classified row word: last flag, label, then the selected value.
  localparam int RowW = VALUE_BITS + 2;

  logic [VALUE_BITS-1:0] feat [FEATURES];
  logic                  q_push;
  logic [RowW-1:0]       q_wdata;
  logic [RowW-1:0]       q_rdata;
  csic_q_stat_t          q_stat;
  csic_bk_stat_t         bk_stat;

  assign feat[0] = in_feature_0;
  assign feat[1] = in_feature_1;
  assign feat[2] = in_feature_2;
  assign feat[3] = in_feature_3;
  assign feat[4] = in_feature_4;
  assign feat[5] = in_feature_5;
  assign feat[6] = in_feature_6;
  assign feat[7] = in_feature_7;

  // Front end: configuration registers, labeling and column selection.
  csic_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_feature    (feat),
    .in_price_value(in_price_value),
    .in_last_row   (in_last_row),
    .q_full        (q_stat.full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  // Queue that decouples the front end from the back end.
  csic_queue #(
    .W(RowW)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (bk_stat.pop),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  // Back end: row storage, statistics and the prediction walk.
  csic_back #(
    .MAX_ROWS  (MAX_ROWS),
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_data               (q_rdata),
    .q_stat               (q_stat),
    .bk_stat              (bk_stat),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_prediction       (out_prediction),
    .out_true_label       (out_true_label),
    .out_correct_so_far   (out_correct_so_far),
    .out_too_few_expensive(out_too_few_expensive),
    .out_last_result      (out_last_result)
  );

  // The queue never holds more words than it has slots.
  `CSIC_NEVER(a_queue_bound, clk, rst_n, q_stat.count > QCNT_W'(QUEUE_DEPTH))
  // The back end only pops a word that is really there.
  `CSIC_ASSERT(a_pop_nonempty, clk, rst_n, bk_stat.pop |-> !q_stat.empty)
  // The input is held back only by a full queue.
  `CSIC_ASSERT(a_stall_cause, clk, rst_n, in_stall |-> q_stat.full)
  // With too few expensive rows every prediction is inside the interval.
  `CSIC_ASSERT(a_few_predicts, clk, rst_n, out_valid && out_too_few_expensive |-> out_prediction)
  // A new result appears only out of the emit walk.
  `CSIC_ASSERT(a_emit_source, clk, rst_n, $rose(out_valid) |-> $past(bk_stat.busy))

endmodule
